@@ rtl/assert_macros.svh @@
// Assertion helpers used by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/slcd_pkg.sv @@
package slcd_pkg;

  // LCD command bytes
  localparam logic [7:0] CMD_PREFIX   = 8'hFE;
  localparam logic [7:0] ADDR_BASE    = 8'h80;
  localparam logic [7:0] LINE2_OFFSET = 8'h30;
  localparam logic [7:0] LINE2_START  = 8'hC0;
  localparam logic [7:0] CLEAR_CODE   = 8'h01;
  localparam logic [7:0] SPACE_CODE   = 8'h20;

  localparam logic [15:0] BIT_TICKS_RESET = 16'd102;
  localparam int          LINE_CHARS_DEF  = 16;

  // Operation codes on the input channel
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_CHAR  = 3'd1;
  localparam logic [2:0] OP_GOTO  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_LINE  = 3'd4;

  // Position limits for go-to
  localparam logic [7:0] POS_LINE1_END = 8'd16;
  localparam logic [7:0] POS_LINE2_END = 8'd32;

  // Serial bit slots
  localparam logic [3:0] SLOT_LAST_DATA = 4'd8;
  localparam logic [3:0] SLOT_STOP      = 4'd9;

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_CMD,
    REQ_NOP
  } req_op_e;

  typedef enum logic [1:0] {
    SEQ_CHAR,
    SEQ_GOTO,
    SEQ_CLEAR,
    SEQ_LINE
  } seq_kind_e;

  // Classified request carried through the queue
  typedef struct packed {
    req_op_e   op;
    seq_kind_e kind;
    logic [7:0] arg;
  } req_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Byte sent at a given step of a sequence
  function automatic logic [7:0] seq_byte(seq_kind_e kind, logic first, logic second,
                                          logic [7:0] arg);
    logic [7:0] b;
    if (kind == SEQ_CHAR) begin
      b = arg;
    end else if (first) begin
      b = CMD_PREFIX;
    end else if (kind == SEQ_CLEAR) begin
      b = CLEAR_CODE;
    end else if (second) begin
      b = arg;
    end else begin
      b = SPACE_CODE;
    end
    return b;
  endfunction

endpackage

@@ rtl/slcd_front.sv @@
module slcd_front import slcd_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] in_operation_i,
  input  logic [7:0] in_char_code_i,
  input  logic [7:0] in_position_i,
  input  logic       in_line_select_i,
  input  q_status_t  q_stat_i,
  output logic       push_o,
  output req_t       push_req_o
);

  // Take a request whenever the queue has room
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  // Classify the operation and prepare the sequence argument
  always_comb begin
    push_req_o.op   = REQ_NOP;
    push_req_o.kind = SEQ_CHAR;
    push_req_o.arg  = '0;
    if (in_operation_i == OP_TICK) begin
      push_req_o.op = REQ_TICK;
    end else if (in_operation_i inside {[OP_CHAR:OP_LINE]}) begin
      push_req_o.op = REQ_CMD;
    end
    case (in_operation_i)
      OP_CHAR: begin
        push_req_o.kind = SEQ_CHAR;
        push_req_o.arg  = in_char_code_i;
      end
      OP_GOTO: begin
        push_req_o.kind = SEQ_GOTO;
        if (in_position_i < POS_LINE1_END) begin
          push_req_o.arg = ADDR_BASE + in_position_i;
        end else if (in_position_i < POS_LINE2_END) begin
          push_req_o.arg = ADDR_BASE + LINE2_OFFSET + in_position_i;
        end else begin
          push_req_o.arg = ADDR_BASE;
        end
      end
      OP_CLEAR: begin
        push_req_o.kind = SEQ_CLEAR;
      end
      OP_LINE: begin
        push_req_o.kind = SEQ_LINE;
        push_req_o.arg  = in_line_select_i ? LINE2_START : ADDR_BASE;
      end
      default: begin
        push_req_o.kind = SEQ_CHAR;
      end
    endcase
  end

endmodule

@@ rtl/slcd_queue.sv @@
module slcd_queue import slcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  req_t      push_req_i,
  input  logic      pop_i,
  output req_t      head_o,
  output q_status_t stat_o
);

  // Two-entry request queue
  req_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

@@ rtl/slcd_back.sv @@
module slcd_back import slcd_pkg::*; #(
  parameter int LineChars = LINE_CHARS_DEF,
  parameter int StepW     = $clog2(LINE_CHARS_DEF + 2)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  q_status_t   q_stat_i,
  input  req_t        head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_tx_line_o,
  output logic        out_busy_res_o,
  output logic        out_accepted_o
);

  localparam logic [StepW:0] LenChar  = (StepW + 1)'(1);
  localparam logic [StepW:0] LenShort = (StepW + 1)'(2);
  localparam logic [StepW:0] LenLine  = (StepW + 1)'(LineChars + 2);

  logic [15:0]      bit_ticks_q;
  logic [15:0]      tick_cnt_q, tick_cnt_d;
  logic [3:0]       slot_q, slot_d;
  logic [7:0]       shift_q, shift_d;
  seq_kind_e        kind_q, kind_d;
  logic [StepW-1:0] step_q, step_d;
  logic [7:0]       arg_q, arg_d;
  logic             busy_q, busy_d;
  logic             level_q, level_d;
  logic             acc;

  logic             out_valid_q;
  logic             out_tx_q, out_busy_q, out_acc_q;

  logic [16:0]      tick_next;
  logic [3:0]       slot_next;
  logic [StepW:0]   step_next;
  logic [StepW:0]   seq_len;

  // Take the next request when the output register is free or draining
  assign pop_o = !q_stat_i.empty && (!out_valid_q || !out_stall_i);

  assign tick_next = {1'b0, tick_cnt_q} + 17'd1;
  assign slot_next = slot_q + 4'd1;
  assign step_next = {1'b0, step_q} + (StepW + 1)'(1);

  always_comb begin
    case (kind_q)
      SEQ_CHAR: seq_len = LenChar;
      SEQ_LINE: seq_len = LenLine;
      default:  seq_len = LenShort;
    endcase
  end

  // Sequencer and bit timer step for one request
  always_comb begin
    tick_cnt_d = tick_cnt_q;
    slot_d     = slot_q;
    shift_d    = shift_q;
    kind_d     = kind_q;
    step_d     = step_q;
    arg_d      = arg_q;
    busy_d     = busy_q;
    level_d    = level_q;
    acc        = 1'b0;
    if (head_i.op == REQ_TICK) begin
      if (busy_q) begin
        if (tick_next < {1'b0, bit_ticks_q}) begin
          tick_cnt_d = tick_next[15:0];
        end else begin
          tick_cnt_d = '0;
          slot_d     = slot_next;
          if (slot_next <= SLOT_LAST_DATA) begin
            level_d = shift_q[slot_q[2:0]];
          end else if (slot_next == SLOT_STOP) begin
            level_d = 1'b1;
          end else if (step_next < seq_len) begin
            step_d  = step_next[StepW-1:0];
            shift_d = seq_byte(kind_q, 1'b0, step_next == (StepW + 1)'(1), arg_q);
            slot_d  = '0;
            level_d = 1'b0;
          end else begin
            busy_d  = 1'b0;
            slot_d  = '0;
            step_d  = '0;
            level_d = 1'b1;
          end
        end
      end
    end else if (head_i.op == REQ_CMD && !busy_q) begin
      acc        = 1'b1;
      kind_d     = head_i.kind;
      arg_d      = head_i.arg;
      step_d     = '0;
      busy_d     = 1'b1;
      shift_d    = seq_byte(head_i.kind, 1'b1, 1'b0, head_i.arg);
      slot_d     = '0;
      tick_cnt_d = '0;
      level_d    = 1'b0;
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_cnt_q <= '0;
      slot_q     <= '0;
      shift_q    <= '0;
      kind_q     <= SEQ_CHAR;
      step_q     <= '0;
      arg_q      <= '0;
      busy_q     <= 1'b0;
      level_q    <= 1'b1;
    end else if (pop_o) begin
      tick_cnt_q <= tick_cnt_d;
      slot_q     <= slot_d;
      shift_q    <= shift_d;
      kind_q     <= kind_d;
      step_q     <= step_d;
      arg_q      <= arg_d;
      busy_q     <= busy_d;
      level_q    <= level_d;
    end
  end

  // Bit period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= BIT_TICKS_RESET;
    end else if (cfg_we_i) begin
      bit_ticks_q <= cfg_wdata_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_tx_q   <= level_d;
      out_busy_q <= busy_d;
      out_acc_q  <= acc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_tx_line_o  = out_tx_q;
  assign out_busy_res_o = out_busy_q;
  assign out_accepted_o = out_acc_q;

endmodule

@@ rtl/serial_lcd_command_transmitter_core.sv @@
// Serial LCD command transmitter.
// Input channel: one request per item, either a timebase tick or an LCD
// command (character, go-to, clear display, clear line). Commands are only
// taken while no byte sequence is in progress; a refused command leaves all
// state alone. Each request produces one result: serial line level, busy
// flag, and whether this request started a sequence.
// Output line: 8N1, LSB first, idle high; each bit lasts bit_ticks ticks,
// bytes of a sequence are sent back to back.
// Config: cfg_we_i writes bit_ticks from cfg_wdata_i; write only when idle.
// Throughput: one request per clock while the receiver does not stall. An
// accepted request is queued in a two-entry buffer and its result is registered
// in the output register when the back end takes it from the queue.
// When the receiver stalls, the result holds in the output register while
// the queue fills; in_stall_o rises once both queue entries are taken.
// Reset: line high, not busy, queue and output empty, bit_ticks = 102.
`include "assert_macros.svh"
module serial_lcd_command_transmitter_core import slcd_pkg::*; #(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_operation_i,
  input  logic [7:0]  in_char_code_i,
  input  logic [7:0]  in_position_i,
  input  logic        in_line_select_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_tx_line_o,
  output logic        out_busy_res_o,
  output logic        out_accepted_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int StepW = $clog2(LINE_CHARS + 2);

  q_status_t q_stat;
  logic      push, pop;
  req_t      push_req, head_req;

  // Front: accept and classify
  slcd_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_operation_i   (in_operation_i),
    .in_char_code_i   (in_char_code_i),
    .in_position_i    (in_position_i),
    .in_line_select_i (in_line_select_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .push_req_o       (push_req)
  );

  // Request queue between front and back
  slcd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_req_i (push_req),
    .pop_i      (pop),
    .head_o     (head_req),
    .stat_o     (q_stat)
  );

  // Back: sequencer, bit timer and result register
  slcd_back #(
    .LineChars (LINE_CHARS),
    .StepW     (StepW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_stat_i       (q_stat),
    .head_i         (head_req),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_tx_line_o  (out_tx_line_o),
    .out_busy_res_o (out_busy_res_o),
    .out_accepted_o (out_accepted_o)
  );

  // An idle result always shows the line high
  `ASSERT_AT(a_idle_high, clk_i, rst_ni, (out_valid_o && !out_busy_res_o) |-> out_tx_line_o)
  // A started sequence is busy and shows its start bit
  `ASSERT_AT(a_acc_start, clk_i, rst_ni,
             (out_valid_o && out_accepted_o) |-> (out_busy_res_o && !out_tx_line_o))
  // Queue status flags are exclusive
  `ASSERT_NEVER(a_q_flags, clk_i, rst_ni, q_stat.full && q_stat.empty)

endmodule
